// ----- src/tgc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the tilt gesture classifier.
// Depends on nothing; used by the top level and by its checker.
package tgc_pkg;

  // Width of the configuration index and of the threshold registers.
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ThrW    = 15;
  localparam int unsigned AccW    = 16;

  typedef logic [2:0]       gesture_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [ThrW-1:0]  thr_t;
  typedef logic [3:0]       orient_t;

  // Gesture and class codes.
  localparam gesture_t G_RIGHT   = 3'd0;
  localparam gesture_t G_RETURN  = 3'd1;
  localparam gesture_t G_LEFT    = 3'd2;
  localparam gesture_t G_UP      = 3'd3;
  localparam gesture_t G_DOWN    = 3'd4;
  localparam gesture_t G_FORWARD = 3'd5;
  localparam gesture_t G_SHAKE   = 3'd6;
  localparam gesture_t G_UNKNOWN = 3'd7;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_ORIENTATION = 3'd0;
  localparam cfg_idx_t CFG_TURN_THR    = 3'd1;
  localparam cfg_idx_t CFG_SHAKE_THR_Y = 3'd2;
  localparam cfg_idx_t CFG_TILT_THR    = 3'd3;
  localparam cfg_idx_t CFG_SHAKE_THR_X = 3'd4;

  // Orientation bits (bit 2, negate Z, has no effect here).
  localparam int unsigned ORIENT_NEG_X = 0;
  localparam int unsigned ORIENT_NEG_Y = 1;
  localparam int unsigned ORIENT_SWAP  = 3;

  // Reset values of the registers.
  localparam orient_t RST_ORIENTATION = 4'd0;
  localparam thr_t    RST_TURN_THR    = 15'd4000;
  localparam thr_t    RST_SHAKE_THR_Y = 15'd1000;
  localparam thr_t    RST_TILT_THR    = 15'd5000;
  localparam thr_t    RST_SHAKE_THR_X = 15'd1000;

endpackage

// ----- src/tilt_gesture_classifier_top.sv -----
`timescale 1ns / 1ps
// Tilt gesture classifier: remap, threshold classification, gesture latch.
// Depends on tgc_pkg.
//
// One accelerometer X/Y word enters per cycle and one result word leaves per
// accepted word, in the following cycle. Remapping, the threshold compares and the
// latch and history update all sit in front of the single result register, so
// the only thing that slows the input is a stalled, full result register:
// in_stall is high exactly while a result waits and out_stall is high.
// Configuration writes are always taken (cfg_ready is tied high); writes to an
// index beyond the register list are accepted and ignored.
module tilt_gesture_classifier_top (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input words.
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [15:0]      in_accel_x,
  input  logic signed [15:0]      in_accel_y,
  input  logic                    in_clear_latch,
  // Result words.
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_gesture_valid,
  output tgc_pkg::gesture_t       out_gesture_code,
  output tgc_pkg::gesture_t       out_sample_class,
  // Configuration writes.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  tgc_pkg::cfg_idx_t       cfg_index,
  input  tgc_pkg::thr_t           cfg_data
);

  tgc_pkg::orient_t  orientation_r;
  tgc_pkg::thr_t     turn_thr_r, shake_thr_y_r, tilt_thr_r, shake_thr_x_r;

  logic              latch_valid_r, latch_valid_nxt;
  tgc_pkg::gesture_t latch_code_r, latch_code_nxt;
  tgc_pkg::gesture_t prev_one_r, prev_two_r, prev_two_nxt;

  logic              out_valid_r;
  logic              gest_valid_r;
  tgc_pkg::gesture_t gest_code_r, class_r;

  logic              in_acc;
  logic signed [15:0] neg_x, neg_y, x_m, y_m;
  logic signed [16:0] xs, ys, turn_p, turn_n, shy_p, shy_n, tilt_p, tilt_n, shx_p, shx_n;
  tgc_pkg::gesture_t cls;
  logic              held, triple, hold;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  // Negation wraps in 16 bits, so the most negative value maps to itself.
  assign neg_x = orientation_r[tgc_pkg::ORIENT_NEG_X] ? -in_accel_x : in_accel_x;
  assign neg_y = orientation_r[tgc_pkg::ORIENT_NEG_Y] ? -in_accel_y : in_accel_y;
  assign x_m   = orientation_r[tgc_pkg::ORIENT_SWAP] ? neg_y : neg_x;
  assign y_m   = orientation_r[tgc_pkg::ORIENT_SWAP] ? neg_x : neg_y;

  assign xs     = {x_m[15], x_m};
  assign ys     = {y_m[15], y_m};
  assign turn_p = {2'b00, turn_thr_r};
  assign turn_n = -turn_p;
  assign shy_p  = {2'b00, shake_thr_y_r};
  assign shy_n  = -shy_p;
  assign tilt_p = {2'b00, tilt_thr_r};
  assign tilt_n = -tilt_p;
  assign shx_p  = {2'b00, shake_thr_x_r};
  assign shx_n  = -shx_p;

  // The Y axis takes priority over X.
  always_comb begin
    if (ys > turn_p) begin
      cls = tgc_pkg::G_LEFT;
    end else if (ys < turn_n) begin
      cls = tgc_pkg::G_RIGHT;
    end else if (ys > shy_p || ys < shy_n) begin
      cls = tgc_pkg::G_SHAKE;
    end else if (xs > tilt_p) begin
      cls = tgc_pkg::G_UP;
    end else if (xs < tilt_n) begin
      cls = tgc_pkg::G_DOWN;
    end else if (xs > shx_p || xs < shx_n) begin
      cls = tgc_pkg::G_SHAKE;
    end else begin
      cls = tgc_pkg::G_UNKNOWN;
    end
  end

  // A clear releases the latch before this word is looked at.
  assign held   = latch_valid_r & ~in_clear_latch;
  assign triple = (cls == prev_one_r) && (prev_one_r == prev_two_r);
  assign hold   = ~held & triple & (cls == tgc_pkg::G_UP || cls == tgc_pkg::G_DOWN);

  always_comb begin
    latch_valid_nxt = held;
    latch_code_nxt  = latch_code_r;
    if (!held) begin
      if (hold) begin
        latch_valid_nxt = 1'b1;
        latch_code_nxt  = (cls == tgc_pkg::G_UP) ? tgc_pkg::G_FORWARD : tgc_pkg::G_RETURN;
      end else if (cls != tgc_pkg::G_UNKNOWN) begin
        latch_valid_nxt = 1'b1;
        latch_code_nxt  = cls;
      end
    end
    prev_two_nxt = hold ? tgc_pkg::G_UNKNOWN : prev_one_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orientation_r <= tgc_pkg::RST_ORIENTATION;
      turn_thr_r    <= tgc_pkg::RST_TURN_THR;
      shake_thr_y_r <= tgc_pkg::RST_SHAKE_THR_Y;
      tilt_thr_r    <= tgc_pkg::RST_TILT_THR;
      shake_thr_x_r <= tgc_pkg::RST_SHAKE_THR_X;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tgc_pkg::CFG_ORIENTATION: orientation_r <= cfg_data[3:0];
        tgc_pkg::CFG_TURN_THR:    turn_thr_r    <= cfg_data;
        tgc_pkg::CFG_SHAKE_THR_Y: shake_thr_y_r <= cfg_data;
        tgc_pkg::CFG_TILT_THR:    tilt_thr_r    <= cfg_data;
        tgc_pkg::CFG_SHAKE_THR_X: shake_thr_x_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_valid_r <= 1'b0;
      latch_code_r  <= tgc_pkg::G_UNKNOWN;
      prev_one_r    <= tgc_pkg::G_UNKNOWN;
      prev_two_r    <= tgc_pkg::G_UNKNOWN;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        latch_valid_r <= latch_valid_nxt;
        latch_code_r  <= latch_code_nxt;
        prev_one_r    <= cls;
        prev_two_r    <= prev_two_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gest_valid_r <= latch_valid_nxt;
      gest_code_r  <= latch_valid_nxt ? latch_code_nxt : tgc_pkg::G_UNKNOWN;
      class_r      <= cls;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_gesture_valid = gest_valid_r;
  assign out_gesture_code  = gest_code_r;
  assign out_sample_class  = class_r;

endmodule

// ----- src/tgc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the tilt gesture classifier, bound to the top level.
// Depends on tgc_pkg and tilt_gesture_classifier_top.
module tgc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_gesture_valid,
  input tgc_pkg::gesture_t out_gesture_code,
  input tgc_pkg::gesture_t out_sample_class
);

  // A word held back at the output stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_gesture_valid)
      && $stable(out_gesture_code) && $stable(out_sample_class))
    else $error("result word changed while stalled");

  // The input is only held off by a full, stalled result register.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // With no gesture held the code reads unknown.
  a_code_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_gesture_valid |-> out_gesture_code == tgc_pkg::G_UNKNOWN)
    else $error("gesture code set without a held gesture");

  // A single sample is never classed as forward or return.
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_class != tgc_pkg::G_FORWARD
      && out_sample_class != tgc_pkg::G_RETURN)
    else $error("sample class is a sequence gesture");

endmodule

bind tilt_gesture_classifier_top tgc_checker u_tgc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_gesture_valid (out_gesture_valid),
  .out_gesture_code  (out_gesture_code),
  .out_sample_class  (out_sample_class)
);

// ----- tb/sv/tb_tilt_gesture_classifier_top.sv -----
`timescale 1ns / 1ps
// Testbench of the tilt gesture classifier: a directed table, then random phases under
// several register settings, each result checked against its table row or a local model of the latch.
// Depends on tgc_pkg and tilt_gesture_classifier_top.
module tb_tilt_gesture_classifier_top;
  import tgc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_WORDS   = 155;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef logic signed [AccW-1:0] accel_t;

  typedef struct packed {
    logic     held;
    gesture_t code;
    gesture_t cls;
  } gesture_word_t;

  typedef struct packed {
    orient_t       orient;
    accel_t        x;
    accel_t        y;
    logic          clear;
    logic          typed;
    gesture_word_t want;
  } dir_row_t;

  localparam gesture_word_t IDLE_WORD = '{1'b0, G_UNKNOWN, G_UNKNOWN};

  // Rows with typed set carry their expected word; the others rely on the model.
  localparam dir_row_t DIR_ROWS [26] = '{
    '{4'd0, 16'sd0, 16'sd0, 1'b0, 1'b1, IDLE_WORD},
    '{4'd0, 16'sd0, 16'sd0, 1'b1, 1'b1, IDLE_WORD},
    '{4'd0, 16'sd0, 16'sd0, 1'b0, 1'b1, IDLE_WORD},
    '{4'd0, 16'sd32767, 16'sd0, 1'b0, 1'b1, '{1'b1, G_UP, G_UP}},
    '{4'd0, 16'sd32767, 16'sd0, 1'b0, 1'b1, '{1'b1, G_UP, G_UP}},
    '{4'd0, 16'sd32767, 16'sd0, 1'b0, 1'b1, '{1'b1, G_UP, G_UP}},
    '{4'd0, 16'sd32767, 16'sd0, 1'b1, 1'b1, '{1'b1, G_FORWARD, G_UP}},
    '{4'd0, 16'sd0, 16'sd0, 1'b1, 1'b1, IDLE_WORD},
    '{4'd0, 16'sh8000, 16'sd0, 1'b1, 1'b1, '{1'b1, G_DOWN, G_DOWN}},
    '{4'd0, 16'sh8000, 16'sd0, 1'b1, 1'b1, '{1'b1, G_DOWN, G_DOWN}},
    '{4'd0, 16'sh8000, 16'sd0, 1'b1, 1'b1, '{1'b1, G_RETURN, G_DOWN}},
    '{4'd0, 16'sd0, 16'sh8000, 1'b1, 1'b1, '{1'b1, G_RIGHT, G_RIGHT}},
    '{4'd0, 16'sd0, 16'sd2000, 1'b0, 1'b1, '{1'b1, G_RIGHT, G_SHAKE}},
    '{4'd0, 16'sd2000, 16'sd0, 1'b1, 1'b1, '{1'b1, G_SHAKE, G_SHAKE}},
    '{4'd0, 16'sd0, 16'sd4000, 1'b1, 1'b1, '{1'b1, G_SHAKE, G_SHAKE}},
    '{4'd0, 16'sd0, 16'sd4001, 1'b1, 1'b1, '{1'b1, G_LEFT, G_LEFT}},
    '{4'd0, 16'sd0, -16'sd4001, 1'b1, 1'b1, '{1'b1, G_RIGHT, G_RIGHT}},
    '{4'd0, 16'sd5000, 16'sd0, 1'b1, 1'b1, '{1'b1, G_SHAKE, G_SHAKE}},
    '{4'd0, 16'sd5001, 16'sd0, 1'b1, 1'b1, '{1'b1, G_UP, G_UP}},
    '{4'd0, 16'sd1000, -16'sd1000, 1'b1, 1'b1, IDLE_WORD},
    '{4'd0, 16'sd32767, 16'sd32767, 1'b0, 1'b1, '{1'b1, G_LEFT, G_LEFT}},
    '{4'd1, 16'sh8000, 16'sd0, 1'b1, 1'b0, IDLE_WORD},
    '{4'd2, 16'sd0, 16'sh8000, 1'b1, 1'b0, IDLE_WORD},
    '{4'd8, 16'sd32767, 16'sd0, 1'b1, 1'b0, IDLE_WORD},
    '{4'd4, 16'sd32767, 16'sd0, 1'b1, 1'b0, IDLE_WORD},
    '{4'd15, 16'sd100, -16'sd5000, 1'b1, 1'b0, IDLE_WORD}
  };

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  accel_t   in_accel_x;
  accel_t   in_accel_y;
  logic     in_clear_latch;
  logic     out_valid;
  logic     out_stall;
  logic     out_gesture_valid;
  gesture_t out_gesture_code;
  gesture_t out_sample_class;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  thr_t     cfg_data;

  // Travels alongside the input word so the monitor knows which expectation to store.
  logic          word_typed;
  gesture_word_t word_want;
  logic          quiet_run;

  // Local copy of the registers and of the gesture state.
  orient_t  orient_reg;
  thr_t     turn_thr;
  thr_t     shake_thr_y;
  thr_t     tilt_thr;
  thr_t     shake_thr_x;
  logic     latch_held;
  gesture_t latch_code;
  gesture_t hist_one;
  gesture_t hist_two;

  gesture_word_t pending_gestures[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;

  tilt_gesture_classifier_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_accel_x       (in_accel_x),
    .in_accel_y       (in_accel_y),
    .in_clear_latch   (in_clear_latch),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_gesture_valid(out_gesture_valid),
    .out_gesture_code (out_gesture_code),
    .out_sample_class (out_sample_class),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic gesture_t tilt_class(input accel_t x, input accel_t y);
    int xi;
    int yi;
    xi = x;
    yi = y;
    if (yi > int'(turn_thr)) return G_LEFT;
    if (yi < -int'(turn_thr)) return G_RIGHT;
    if (yi > int'(shake_thr_y) || yi < -int'(shake_thr_y)) return G_SHAKE;
    if (xi > int'(tilt_thr)) return G_UP;
    if (xi < -int'(tilt_thr)) return G_DOWN;
    if (xi > int'(shake_thr_x) || xi < -int'(shake_thr_x)) return G_SHAKE;
    return G_UNKNOWN;
  endfunction

  task automatic advance_gesture(input accel_t ax, input accel_t ay, input logic clear,
                                 output gesture_word_t w);
    accel_t   x;
    accel_t   y;
    gesture_t cls;
    logic     upgrade;
    upgrade = 1'b0;
    if (clear) latch_held = 1'b0;
    // Negation wraps at 16 bits, so the most negative value maps onto itself.
    x = orient_reg[ORIENT_NEG_X] ? -ax : ax;
    y = orient_reg[ORIENT_NEG_Y] ? -ay : ay;
    if (orient_reg[ORIENT_SWAP]) begin
      cls = tilt_class(y, x);
    end else begin
      cls = tilt_class(x, y);
    end
    if (!latch_held) begin
      if (cls != G_UNKNOWN) begin
        latch_held = 1'b1;
        latch_code = cls;
      end
      if (cls == hist_one && hist_one == hist_two && (cls == G_UP || cls == G_DOWN)) begin
        upgrade    = 1'b1;
        latch_held = 1'b1;
        latch_code = (cls == G_UP) ? G_FORWARD : G_RETURN;
      end
    end
    hist_two = upgrade ? G_UNKNOWN : hist_one;
    hist_one = cls;
    w.held = latch_held;
    w.code = latch_held ? latch_code : G_UNKNOWN;
    w.cls  = cls;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // All sampling happens here, at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    gesture_word_t w;
    gesture_word_t e;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      cycle_count++;
      if (rst_n && cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIENTATION: orient_reg  = orient_t'(cfg_data);
          CFG_TURN_THR:    turn_thr    = cfg_data;
          CFG_SHAKE_THR_Y: shake_thr_y = cfg_data;
          CFG_TILT_THR:    tilt_thr    = cfg_data;
          CFG_SHAKE_THR_X: shake_thr_x = cfg_data;
          default: ;
        endcase
      end
      if (rst_n && in_valid && !in_stall) begin
        advance_gesture(in_accel_x, in_accel_y, in_clear_latch, w);
        pending_gestures = {pending_gestures, (word_typed ? word_want : w)};
      end
      if (rst_n && out_valid && !out_stall) begin
        if (pending_gestures.size() == 0) begin
          report_mismatch("unexpected word", out_sample_class, 0);
        end else begin
          e = pending_gestures.pop_front();
          if (out_gesture_valid !== e.held)
            report_mismatch("gesture_valid", out_gesture_valid, e.held);
          if (out_gesture_code !== e.code)
            report_mismatch("gesture_code", out_gesture_code, e.code);
          if (out_sample_class !== e.cls)
            report_mismatch("sample_class", out_sample_class, e.cls);
        end
      end
    end
  end

  // Result side: a random stall before each word, none during quiet stretches.
  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      hold = quiet_run ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic accel_t clamp_axis(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return accel_t'(v);
  endfunction

  function automatic accel_t pick_axis();
    accel_t ext [4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    thr_t   pick;
    int     v;
    case ($urandom_range(0, 3))
      0: return accel_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       pick = turn_thr;
          1:       pick = shake_thr_y;
          2:       pick = tilt_thr;
          default: pick = shake_thr_x;
        endcase
        v = int'(pick) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
        return clamp_axis(v);
      end
      2: return ext[2'($urandom_range(0, 3))];
      default: return accel_t'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input accel_t x, input accel_t y, input logic clear,
                           input logic typed, input gesture_word_t want);
    int unsigned gap;
    gap = quiet_run ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_accel_x     = x;
    in_accel_y     = y;
    in_clear_latch = clear;
    word_typed     = typed;
    word_want      = want;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write of a group.
  task automatic write_reg(input cfg_idx_t idx, input thr_t data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    dir_row_t    r;
    thr_t        thr [4];
    orient_t     o;
    int unsigned sent;
    int unsigned run_len;
    accel_t      px;
    accel_t      py;
    accel_t      jx;
    accel_t      jy;
    accel_t      ax;
    accel_t      ay;
    logic        clear;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_accel_x     = '0;
    in_accel_y     = '0;
    in_clear_latch = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_ORIENTATION;
    cfg_data       = '0;
    word_typed     = 1'b0;
    word_want      = IDLE_WORD;
    quiet_run      = 1'b0;
    orient_reg     = RST_ORIENTATION;
    turn_thr       = RST_TURN_THR;
    shake_thr_y    = RST_SHAKE_THR_Y;
    tilt_thr       = RST_TILT_THR;
    shake_thr_x    = RST_SHAKE_THR_X;
    latch_held     = 1'b0;
    latch_code     = G_UNKNOWN;
    hist_one       = G_UNKNOWN;
    hist_two       = G_UNKNOWN;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIR_ROWS[i]) begin
      r = DIR_ROWS[i];
      if (r.orient != orient_reg) begin
        wait_idle();
        write_reg(CFG_ORIENTATION, thr_t'(r.orient));
        cfg_valid = 1'b0;
      end
      send_word(r.x, r.y, r.clear, r.typed, r.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      // Waiting for every outstanding word here also holds the sender off completely.
      wait_idle();
      case (p)
        0: begin
          o   = RST_ORIENTATION;
          thr = '{RST_TURN_THR, RST_SHAKE_THR_Y, RST_TILT_THR, RST_SHAKE_THR_X};
        end
        1: begin
          o   = '1;
          thr = '{'0, '0, '0, '0};
        end
        2: begin
          o   = orient_t'($urandom_range(0, 15));
          thr = '{'1, '1, '1, '1};
        end
        default: begin
          o = orient_t'($urandom_range(0, 15));
          foreach (thr[k])
            thr[k] = ($urandom_range(0, 3) == 0) ? thr_t'($urandom_range(0, 32767))
                                                 : thr_t'($urandom_range(0, 8000));
        end
      endcase
      write_reg(CFG_ORIENTATION, thr_t'(o));
      write_reg(CFG_TURN_THR, thr[0]);
      write_reg(CFG_SHAKE_THR_Y, thr[1]);
      write_reg(CFG_TILT_THR, thr[2]);
      write_reg(CFG_SHAKE_THR_X, thr[3]);
      cfg_valid = 1'b0;

      sent = 0;
      while (sent < PHASE_WORDS) begin
        quiet_run = (p % 3 == 1) && (sent < 40);
        if ($urandom_range(0, 9) < 6) begin
          // A run of near-equal samples; steep X tilts mostly, so that three equal
          // up or down classes in a row occur often enough to upgrade the latch.
          run_len = $urandom_range(3, 5);
          if ($urandom_range(0, 3) != 0) begin
            px = clamp_axis(int'(tilt_thr) + int'($urandom_range(1, 3000)));
            if ($urandom_range(0, 1)) px = -px;
            py = accel_t'($urandom_range(0, shake_thr_y));
            if ($urandom_range(0, 1)) py = -py;
          end else begin
            px = pick_axis();
            py = pick_axis();
          end
          for (int k = 0; k < run_len; k++) begin
            jx = clamp_axis(int'(px) + int'($urandom_range(0, 20)) - 10);
            jy = clamp_axis(int'(py) + int'($urandom_range(0, 20)) - 10);
            // Undo the remapping so the block sees the intended tilt.
            if (orient_reg[ORIENT_SWAP]) begin
              ax = jy;
              ay = jx;
            end else begin
              ax = jx;
              ay = jy;
            end
            if (orient_reg[ORIENT_NEG_X]) ax = -ax;
            if (orient_reg[ORIENT_NEG_Y]) ay = -ay;
            clear = (k == run_len - 1) ? ($urandom_range(0, 3) != 0)
                                       : 1'($urandom_range(0, 1));
            send_word(ax, ay, clear, 1'b0, IDLE_WORD);
            sent++;
          end
        end else begin
          send_word(pick_axis(), pick_axis(), 1'($urandom_range(0, 1)), 1'b0, IDLE_WORD);
          sent++;
        end
      end
    end

    quiet_run = 1'b0;
    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
